[design/lpfs_pkg.sv]
// Shared types and constants for the length-prefixed frame splitter.
package lpfs_pkg;

    localparam int BYTE_W        = 8;
    localparam int POS_WIDTH     = 32;
    localparam int FLEN_W        = 32;
    localparam int LEN_WIDTH_DEF = 32;

    localparam int OFFSET_W      = 4;
    localparam int FBYTES_W      = 3;
    localparam int HDR_END_W     = 5;

    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 4;

    localparam logic [OFFSET_W-1:0] OFFSET_RST     = 4'd0;
    localparam logic [FBYTES_W-1:0] FBYTES_RST     = 3'd4;
    localparam logic                BIG_ENDIAN_RST = 1'b0;

    localparam logic [FBYTES_W-1:0] FBYTES_MIN = 3'd1;
    localparam logic [FBYTES_W-1:0] FBYTES_MAX = 3'd4;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LEN_FIELD_OFFSET = 2'd0,
        CFG_LEN_FIELD_BYTES  = 2'd1,
        CFG_LEN_BIG_ENDIAN   = 2'd2
    } cfg_index_t;

    // Active configuration, with the field width already clamped to 1..4.
    typedef struct packed {
        logic [OFFSET_W-1:0]  offset;
        logic [FBYTES_W-1:0]  field_bytes;
        logic                 big_endian;
        logic [HDR_END_W-1:0] hdr_end;
    } cfg_t;

    // Frame marks that go with one byte.
    typedef struct packed {
        logic first;
        logic last;
        logic err;
    } frame_flags_t;

endpackage

[design/length_prefixed_frame_splitter.sv]
// Top level of the length-prefixed frame splitter: request pipeline and frame state.
//
//   Channel   Signals                                   Direction  Carries
//   item      item_valid, item_stall, data_in           in         one stream byte per request
//   result    result_valid, result_stall, data_out,     out        the byte with frame marks,
//             frame_start, frame_end, frame_length,                length and error flag
//             length_error
//   cfg       cfg_valid, cfg_ready, cfg_index, cfg_data in         register writes
//
// One byte per clock while the result is not stalled; a request taken passes the input stage
// register, then the result register. The per-byte frame state loop (position, length field,
// header flag) is combinational logic from its own registers. Reset clears both stages and the
// frame state and loads offset 0, a four-byte field and little-endian order.
// A stalled result holds; item_stall rises only while the input stage is full and the
// result register holds a stalled result.
module length_prefixed_frame_splitter #(
    parameter int LEN_WIDTH = lpfs_pkg::LEN_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             item_valid,
    output logic                             item_stall,
    input  logic [lpfs_pkg::BYTE_W-1:0]      data_in,

    output logic                             result_valid,
    input  logic                             result_stall,
    output logic [lpfs_pkg::BYTE_W-1:0]      data_out,
    output logic                             frame_start,
    output logic                             frame_end,
    output logic [lpfs_pkg::FLEN_W-1:0]      frame_length,
    output logic                             length_error,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lpfs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lpfs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lpfs_pkg::*;

    cfg_t                  cfg;

    // Input stage.
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic [BYTE_W-1:0]     s1_data_reg;

    // Frame state, advanced once per byte leaving the input stage.
    logic [POS_WIDTH-1:0]  pos_reg;
    logic [POS_WIDTH-1:0]  pos_next;
    logic [LEN_WIDTH-1:0]  accum_reg;
    logic [LEN_WIDTH-1:0]  accum_next;
    logic                  known_reg;
    logic                  known_next;

    // Result stage.
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [BYTE_W-1:0]     out_data_reg;
    frame_flags_t          out_flags_reg;
    frame_flags_t          step_flags;
    logic [FLEN_W-1:0]     out_flen_reg;
    logic [FLEN_W-1:0]     step_flen;

    logic                  out_blocked;
    logic                  item_take;
    logic                  s1_move;

    // The register file takes a write every cycle; write only while idle (not enforced).
    assign cfg_ready = 1'b1;

    lpfs_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    lpfs_step #(
        .LEN_WIDTH (LEN_WIDTH)
    ) u_step (
        .cfg          (cfg),
        .data         (s1_data_reg),
        .pos          (pos_reg),
        .accum        (accum_reg),
        .known        (known_reg),
        .pos_next     (pos_next),
        .accum_next   (accum_next),
        .known_next   (known_next),
        .flags        (step_flags),
        .frame_length (step_flen)
    );

    // Handshake: the result register is blocked only while it holds a stalled result.
    assign out_blocked = out_valid_reg && result_stall;
    assign s1_move     = s1_valid_reg && !out_blocked;
    assign item_stall  = s1_valid_reg && out_blocked;
    assign item_take   = item_valid && !item_stall;

    assign s1_valid_next  = item_take || (s1_valid_reg && !s1_move);
    assign out_valid_next = s1_move || out_blocked;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            accum_reg     <= '0;
            known_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_move)
            begin
                pos_reg   <= pos_next;
                accum_reg <= accum_next;
                known_reg <= known_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (item_take)
            s1_data_reg <= data_in;
        if (s1_move)
        begin
            out_data_reg  <= s1_data_reg;
            out_flags_reg <= step_flags;
            out_flen_reg  <= step_flen;
        end
    end

    assign result_valid = out_valid_reg;
    assign data_out     = out_data_reg;
    assign frame_start  = out_flags_reg.first;
    assign frame_end    = out_flags_reg.last;
    assign frame_length = out_flen_reg;
    assign length_error = out_flags_reg.err;

`ifndef NO_ASSERTIONS
    // A length error always closes the frame.
    a_err_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && length_error |-> frame_end)
        else $error("length error reported without frame end");

    // A length is reported only on the last byte of a frame.
    a_len_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !frame_end |-> frame_length == '0)
        else $error("frame length nonzero away from frame end");

    // After a frame closes, the next byte processed starts a new frame.
    a_end_then_start: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move && step_flags.last |=> pos_reg == '0 && !known_reg)
        else $error("frame state not cleared after frame end");

    // The input stage stalls only while both stages are occupied.
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> s1_valid_reg && out_valid_reg)
        else $error("input stalled with a free stage");
`endif

endmodule

[design/lpfs_cfg_regs.sv]
// Configuration registers of the frame splitter and the derived header end.
module lpfs_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [lpfs_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [lpfs_pkg::CFG_DATA_W-1:0]  wr_data,
    output lpfs_pkg::cfg_t                   cfg
);
    import lpfs_pkg::*;

    logic [OFFSET_W-1:0] offset_reg;
    logic [FBYTES_W-1:0] fbytes_reg;
    logic                big_endian_reg;
    logic [FBYTES_W-1:0] fbytes_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg     <= OFFSET_RST;
            fbytes_reg     <= FBYTES_RST;
            big_endian_reg <= BIG_ENDIAN_RST;
        end
        else if (wr_en)
        begin
            case (cfg_index_t'(wr_index))
                CFG_LEN_FIELD_OFFSET: offset_reg     <= wr_data[OFFSET_W-1:0];
                CFG_LEN_FIELD_BYTES:  fbytes_reg     <= wr_data[FBYTES_W-1:0];
                CFG_LEN_BIG_ENDIAN:   big_endian_reg <= wr_data[0];
                default: ;
            endcase
        end
    end

    // A width of zero behaves as one byte, anything above four as four.
    always_comb
    begin
        case (fbytes_reg) inside
            [FBYTES_MIN:FBYTES_MAX]: fbytes_eff = fbytes_reg;
            3'd0:                    fbytes_eff = FBYTES_MIN;
            default:                 fbytes_eff = FBYTES_MAX;
        endcase
    end

    assign cfg.offset      = offset_reg;
    assign cfg.field_bytes = fbytes_eff;
    assign cfg.big_endian  = big_endian_reg;
    assign cfg.hdr_end     = HDR_END_W'(offset_reg) + HDR_END_W'(fbytes_eff);

endmodule

[design/lpfs_step.sv]
// Per-byte frame logic: length field assembly, byte count and end decision.
module lpfs_step #(
    parameter int LEN_WIDTH = lpfs_pkg::LEN_WIDTH_DEF
) (
    input  lpfs_pkg::cfg_t                   cfg,
    input  logic [lpfs_pkg::BYTE_W-1:0]      data,
    input  logic [lpfs_pkg::POS_WIDTH-1:0]   pos,
    input  logic [LEN_WIDTH-1:0]             accum,
    input  logic                             known,
    output logic [lpfs_pkg::POS_WIDTH-1:0]   pos_next,
    output logic [LEN_WIDTH-1:0]             accum_next,
    output logic                             known_next,
    output lpfs_pkg::frame_flags_t           flags,
    output logic [lpfs_pkg::FLEN_W-1:0]      frame_length
);
    import lpfs_pkg::*;

    logic                      start;
    logic [LEN_WIDTH-1:0]      acc_cur;
    logic                      known_cur;
    logic [POS_WIDTH-1:0]      offset_ext;
    logic [POS_WIDTH-1:0]      hdr_end_ext;
    logic                      in_field;
    logic [1:0]                lane;
    logic [POS_WIDTH-1:0]      le_shifted;
    logic [LEN_WIDTH+BYTE_W-1:0] be_shifted;
    logic [LEN_WIDTH-1:0]      acc_new;
    logic [POS_WIDTH-1:0]      acc_ext;
    logic [POS_WIDTH-1:0]      count;
    logic                      hdr_done;
    logic                      too_short;
    logic                      last;

    assign start     = (pos == '0);
    assign acc_cur   = start ? '0 : accum;
    assign known_cur = start ? 1'b0 : known;

    assign offset_ext  = POS_WIDTH'(cfg.offset);
    assign hdr_end_ext = POS_WIDTH'(cfg.hdr_end);
    assign in_field    = !known_cur && (pos >= offset_ext) && (pos < hdr_end_ext);

    // Little-endian: the byte lands in the lane given by its place in the field.
    assign lane       = pos[1:0] - cfg.offset[1:0];
    assign le_shifted = POS_WIDTH'(data) << {lane, 3'b000};
    // Big-endian: shift the field so far up one byte and append.
    assign be_shifted = {acc_cur, data};

    always_comb
    begin
        if (!in_field)
            acc_new = acc_cur;
        else if (cfg.big_endian)
            acc_new = be_shifted[LEN_WIDTH-1:0];
        else
            acc_new = acc_cur | le_shifted[LEN_WIDTH-1:0];
    end

    assign acc_ext = POS_WIDTH'(acc_new);
    assign count   = (&pos) ? pos : pos + POS_WIDTH'(1);

    assign hdr_done  = !known_cur && (count >= hdr_end_ext);
    assign too_short = hdr_done && (acc_ext < hdr_end_ext);
    assign last      = too_short || ((hdr_done || known_cur) && (count >= acc_ext));

    assign pos_next     = last ? '0 : count;
    assign accum_next   = last ? '0 : acc_new;
    assign known_next   = last ? 1'b0 : (known_cur || hdr_done);
    assign flags.first  = start;
    assign flags.last   = last;
    assign flags.err    = too_short;
    assign frame_length = last ? FLEN_W'(acc_ext) : '0;

endmodule
